// ----- rtl/ccc_pkg.sv -----
// Package for the circle-circle contact core: widths, step counts and the
// stage record types used by the front, the queue and the back end.
// No dependencies.
package ccc_pkg;
   localparam int DIST_W     = 31;
   localparam int RAD_W      = 30;
   localparam int SUM_W      = 62;
   localparam int PROD_W     = 61;
   localparam int NORM_W     = 18;
   localparam int PEN_W      = 31;
   localparam int SQ_STEPS   = 31;
   localparam int NQ_STEPS   = 17;
   localparam int PQ_STEPS   = 30;
   localparam int NORM_FRAC  = 16;
   localparam int FIFO_DEPTH = 2;
   localparam logic signed [NORM_W-1:0] NORM_ONE = 18'sd65536;

   typedef struct packed {
      logic                     far;
      logic                     sx;
      logic                     sy;
      logic [DIST_W-1:0]        mx;
      logic [DIST_W-1:0]        my;
      logic [RAD_W-1:0]         ra;
      logic [DIST_W-1:0]        r;
      logic signed [31:0]       ax;
      logic signed [31:0]       ay;
      logic [SUM_W-1:0]         mx2;
      logic [SUM_W-1:0]         my2;
      logic [SUM_W-1:0]         rr;
      logic [PROD_W-1:0]        mxra;
      logic [PROD_W-1:0]        myra;
   } front_type;

   typedef struct packed {
      logic                     contact;
      logic                     sx;
      logic                     sy;
      logic [DIST_W-1:0]        mx;
      logic [DIST_W-1:0]        my;
      logic [RAD_W-1:0]         ra;
      logic [DIST_W-1:0]        r;
      logic signed [31:0]       ax;
      logic signed [31:0]       ay;
      logic [PROD_W-1:0]        mxra;
      logic [PROD_W-1:0]        myra;
   } carry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;
endpackage

// ----- rtl/ccc_if.sv -----
// Channel interfaces for the circle-circle contact core.
// Depends on ccc_pkg for field widths.
interface ccc_req_if import ccc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [31:0] first_x;
   logic signed [31:0] first_y;
   logic [RAD_W-1:0]   first_radius;
   logic signed [31:0] second_x;
   logic signed [31:0] second_y;
   logic [RAD_W-1:0]   second_radius;
   modport source (output valid, first_x, first_y, first_radius, second_x, second_y,
                   second_radius, input ready);
   modport sink (input valid, first_x, first_y, first_radius, second_x, second_y,
                 second_radius, output ready);
endinterface

interface ccc_rsp_if import ccc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     contact_found;
   logic [PEN_W-1:0]         penetration;
   logic signed [NORM_W-1:0] normal_x;
   logic signed [NORM_W-1:0] normal_y;
   logic signed [31:0]       point_x;
   logic signed [31:0]       point_y;
   modport source (output valid, contact_found, penetration, normal_x, normal_y,
                   point_x, point_y, input ready);
   modport sink (input valid, contact_found, penetration, normal_x, normal_y,
                 point_x, point_y, output ready);
endinterface

// ----- rtl/circle_circle_contact_core.sv -----
// Circle-circle contact core: circle pair in on req_ch, one contact result
// out on rsp_ch, both valid/ready channels; an item moves when both are high.
// Each pair gives exactly one result, in order. contact_found is 0 and all
// other fields are zero when the circles are apart.
// Throughput: one item per cycle, sustained, while rsp_ch is taken.
// From the accepting edge to rsp_ch.valid an item passes through two front
// stages (offsets, squares; the first loads on the accepting edge), the
// queue, one contact-test stage, 31 square root stages (one result bit
// each), a divider load stage, 30 divider stages (one quotient bit each)
// and the output register.
// When the receiver stalls, the back end holds and the two-entry queue
// absorbs what the front end has in flight; req_ch.ready drops once the
// queue is full and the front end holds an item.
// Reset clears all valid flags; the block is ready the cycle after.
// Depends on ccc_pkg, ccc_if, ccc_front, ccc_fifo and ccc_back.
module circle_circle_contact_core import ccc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ccc_req_if.sink   req_ch,
   ccc_rsp_if.source rsp_ch
);
   logic          push, pop;
   front_type     push_data, pop_data;
   fifo_stat_type fifo_stat;

   ccc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .fifo_full (fifo_stat.full),
      .push      (push),
      .push_data (push_data)
   );

   ccc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   ccc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (!fifo_stat.empty),
      .in_data  (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

   a_no_contact_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.contact_found) |->
      (rsp_ch.penetration == '0 && rsp_ch.normal_x == '0 && rsp_ch.normal_y == '0
       && rsp_ch.point_x == '0 && rsp_ch.point_y == '0))
      else $error("non-contact result carries data");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.normal_x <= NORM_ONE && rsp_ch.normal_x >= -NORM_ONE
                        && rsp_ch.normal_y <= NORM_ONE && rsp_ch.normal_y >= -NORM_ONE))
      else $error("normal component out of range");

   a_fifo_stat: assert property (@(posedge clock) disable iff (reset)
      !(fifo_stat.full && fifo_stat.empty) && !(push && fifo_stat.full)
      && !(pop && fifo_stat.empty))
      else $error("queue overflow or underflow");
endmodule

// ----- rtl/ccc_front.sv -----
// Front end: accepts pairs, forms centre offsets, far test, the squares and the offset-radius products.
// Depends on ccc_pkg and ccc_req_if.
module ccc_front import ccc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ccc_req_if.sink     req_ch,
   input  logic        fifo_full,
   output logic        push,
   output front_type   push_data
);
   logic               en;
   logic               s1_v_ff, s2_v_ff;
   front_type          s1_ff, s1_in, s2_ff, s2_in;
   logic signed [32:0] dx, dy;
   logic [32:0]        ax33, ay33;

   assign en         = !(s2_v_ff && fifo_full);
   assign req_ch.ready = en;
   assign push       = s2_v_ff && !fifo_full;
   assign push_data  = s2_ff;

   always_comb begin
      dx   = {req_ch.second_x[31], req_ch.second_x} - {req_ch.first_x[31], req_ch.first_x};
      dy   = {req_ch.second_y[31], req_ch.second_y} - {req_ch.first_y[31], req_ch.first_y};
      ax33 = dx[32] ? 33'(-dx) : 33'(dx);
      ay33 = dy[32] ? 33'(-dy) : 33'(dy);
      s1_in    = '0;
      s1_in.r  = {1'b0, req_ch.first_radius} + {1'b0, req_ch.second_radius};
      s1_in.far = (ax33 > {2'b0, s1_in.r}) || (ay33 > {2'b0, s1_in.r});
      s1_in.sx = dx[32];
      s1_in.sy = dy[32];
      s1_in.mx = ax33[DIST_W-1:0];
      s1_in.my = ay33[DIST_W-1:0];
      s1_in.ra = req_ch.first_radius;
      s1_in.ax = req_ch.first_x;
      s1_in.ay = req_ch.first_y;
   end

   always_comb begin
      s2_in      = s1_ff;
      s2_in.mx2  = s1_ff.mx * s1_ff.mx;
      s2_in.my2  = s1_ff.my * s1_ff.my;
      s2_in.rr   = s1_ff.r * s1_ff.r;
      s2_in.mxra = s1_ff.mx * s1_ff.ra;
      s2_in.myra = s1_ff.my * s1_ff.ra;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_ch.valid;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end
endmodule

// ----- rtl/ccc_fifo.sv -----
// Two-entry queue between the front end and the back end.
// Depends on ccc_pkg.
module ccc_fifo import ccc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  front_type     push_data,
   input  logic          pop,
   output front_type     pop_data,
   output fifo_stat_type stat
);
   front_type  mem_ff [FIFO_DEPTH];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign stat.full  = (cnt_ff == 2'(FIFO_DEPTH));
   assign stat.empty = (cnt_ff == 2'd0);
   assign pop_data   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ----- rtl/ccc_back.sv -----
// Back end: contact test, bit-per-stage square root, restoring dividers and
// result assembly into the output register. Depends on ccc_pkg, ccc_rsp_if.
module ccc_back import ccc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      pop,
   ccc_rsp_if.source rsp_ch
);
   logic adv;
   logic rsp_v_ff;

   logic              sq_v_ff   [SQ_STEPS+1];
   carry_type         sq_c_ff   [SQ_STEPS+1];
   logic [63:0]       sq_rem_ff [SQ_STEPS+1];
   logic [DIST_W-1:0] sq_res_ff [SQ_STEPS+1];

   logic              dv_v_ff    [PQ_STEPS+1];
   carry_type         dv_c_ff    [PQ_STEPS+1];
   logic [DIST_W-1:0] dv_d_ff    [PQ_STEPS+1];
   logic [DIST_W-1:0] dv_nxr_ff  [PQ_STEPS+1];
   logic [DIST_W-1:0] dv_nyr_ff  [PQ_STEPS+1];
   logic [NQ_STEPS-1:0] dv_nxn_ff [PQ_STEPS+1];
   logic [NQ_STEPS-1:0] dv_nyn_ff [PQ_STEPS+1];
   logic [NQ_STEPS-1:0] dv_nxq_ff [PQ_STEPS+1];
   logic [NQ_STEPS-1:0] dv_nyq_ff [PQ_STEPS+1];
   logic [DIST_W-1:0] dv_pxr_ff  [PQ_STEPS+1];
   logic [DIST_W-1:0] dv_pyr_ff  [PQ_STEPS+1];
   logic [PQ_STEPS-1:0] dv_pxn_ff [PQ_STEPS+1];
   logic [PQ_STEPS-1:0] dv_pyn_ff [PQ_STEPS+1];
   logic [PQ_STEPS-1:0] dv_pxq_ff [PQ_STEPS+1];
   logic [PQ_STEPS-1:0] dv_pyq_ff [PQ_STEPS+1];

   logic [SUM_W:0] sum;
   carry_type      b0_in;

   assign adv          = !rsp_v_ff || rsp_ch.ready;
   assign pop          = adv && in_valid;
   assign rsp_ch.valid = rsp_v_ff;

   always_comb begin
      sum           = {1'b0, in_data.mx2} + {1'b0, in_data.my2};
      b0_in.contact = !in_data.far && (sum <= {1'b0, in_data.rr});
      b0_in.sx      = in_data.sx;
      b0_in.sy      = in_data.sy;
      b0_in.mx      = in_data.mx;
      b0_in.my      = in_data.my;
      b0_in.ra      = in_data.ra;
      b0_in.r       = in_data.r;
      b0_in.ax      = in_data.ax;
      b0_in.ay      = in_data.ay;
      b0_in.mxra    = in_data.mxra;
      b0_in.myra    = in_data.myra;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_c_ff[0]   <= b0_in;
         sq_rem_ff[0] <= {2'b0, sum[SUM_W-1:0]};
         sq_res_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
      logic [63:0] trial;
      logic        ge;
      assign trial = ({33'd0, sq_res_ff[k]} << (SQ_STEPS - k))
                   + (64'd1 << (2 * (SQ_STEPS - 1 - k)));
      assign ge    = sq_rem_ff[k] >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_c_ff[k+1]   <= sq_c_ff[k];
            sq_rem_ff[k+1] <= ge ? sq_rem_ff[k] - trial : sq_rem_ff[k];
            sq_res_ff[k+1] <= ge ? sq_res_ff[k] | (DIST_W'(1) << (SQ_STEPS - 1 - k))
                                 : sq_res_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_c_ff[0]   <= sq_c_ff[SQ_STEPS];
         dv_d_ff[0]   <= sq_res_ff[SQ_STEPS];
         dv_nxr_ff[0] <= {1'b0, sq_c_ff[SQ_STEPS].mx[DIST_W-1:1]};
         dv_nyr_ff[0] <= {1'b0, sq_c_ff[SQ_STEPS].my[DIST_W-1:1]};
         dv_nxn_ff[0] <= {sq_c_ff[SQ_STEPS].mx[0], 16'd0};
         dv_nyn_ff[0] <= {sq_c_ff[SQ_STEPS].my[0], 16'd0};
         dv_nxq_ff[0] <= '0;
         dv_nyq_ff[0] <= '0;
         dv_pxr_ff[0] <= sq_c_ff[SQ_STEPS].mxra[PROD_W-1:PQ_STEPS];
         dv_pyr_ff[0] <= sq_c_ff[SQ_STEPS].myra[PROD_W-1:PQ_STEPS];
         dv_pxn_ff[0] <= sq_c_ff[SQ_STEPS].mxra[PQ_STEPS-1:0];
         dv_pyn_ff[0] <= sq_c_ff[SQ_STEPS].myra[PQ_STEPS-1:0];
         dv_pxq_ff[0] <= '0;
         dv_pyq_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < PQ_STEPS; k++) begin : g_dv
      logic [DIST_W:0] dd, txn, tyn, txp, typ;
      logic            gxn, gyn, gxp, gyp;
      assign dd  = {1'b0, dv_d_ff[k]};
      assign txn = {dv_nxr_ff[k], dv_nxn_ff[k][NQ_STEPS-1]};
      assign tyn = {dv_nyr_ff[k], dv_nyn_ff[k][NQ_STEPS-1]};
      assign txp = {dv_pxr_ff[k], dv_pxn_ff[k][PQ_STEPS-1]};
      assign typ = {dv_pyr_ff[k], dv_pyn_ff[k][PQ_STEPS-1]};
      assign gxn = txn >= dd;
      assign gyn = tyn >= dd;
      assign gxp = txp >= dd;
      assign gyp = typ >= dd;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_c_ff[k+1]   <= dv_c_ff[k];
            dv_d_ff[k+1]   <= dv_d_ff[k];
            dv_pxr_ff[k+1] <= DIST_W'(gxp ? txp - dd : txp);
            dv_pyr_ff[k+1] <= DIST_W'(gyp ? typ - dd : typ);
            dv_pxn_ff[k+1] <= dv_pxn_ff[k] << 1;
            dv_pyn_ff[k+1] <= dv_pyn_ff[k] << 1;
            dv_pxq_ff[k+1] <= {dv_pxq_ff[k][PQ_STEPS-2:0], gxp};
            dv_pyq_ff[k+1] <= {dv_pyq_ff[k][PQ_STEPS-2:0], gyp};
            if (k < NQ_STEPS) begin
               dv_nxr_ff[k+1] <= DIST_W'(gxn ? txn - dd : txn);
               dv_nyr_ff[k+1] <= DIST_W'(gyn ? tyn - dd : tyn);
               dv_nxn_ff[k+1] <= dv_nxn_ff[k] << 1;
               dv_nyn_ff[k+1] <= dv_nyn_ff[k] << 1;
               dv_nxq_ff[k+1] <= {dv_nxq_ff[k][NQ_STEPS-2:0], gxn};
               dv_nyq_ff[k+1] <= {dv_nyq_ff[k][NQ_STEPS-2:0], gyn};
            end else begin
               dv_nxr_ff[k+1] <= dv_nxr_ff[k];
               dv_nyr_ff[k+1] <= dv_nyr_ff[k];
               dv_nxn_ff[k+1] <= dv_nxn_ff[k];
               dv_nyn_ff[k+1] <= dv_nyn_ff[k];
               dv_nxq_ff[k+1] <= dv_nxq_ff[k];
               dv_nyq_ff[k+1] <= dv_nyq_ff[k];
            end
         end
      end
   end

   carry_type                fc;
   logic [DIST_W-1:0]        fd;
   logic                     contact_in;
   logic [PEN_W-1:0]         pen_in;
   logic signed [NORM_W-1:0] nx_in, ny_in;
   logic signed [33:0]       px_full, py_full;
   logic signed [31:0]       px_in, py_in;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] res;
      if (v > 34'sh0_7FFF_FFFF) res = 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) res = 32'sh8000_0000;
      else res = v[31:0];
      return res;
   endfunction

   always_comb begin
      fc         = dv_c_ff[PQ_STEPS];
      fd         = dv_d_ff[PQ_STEPS];
      contact_in = fc.contact;
      px_full    = 34'(fc.ax) + (fc.sx ? -34'({4'd0, dv_pxq_ff[PQ_STEPS]})
                                       : 34'({4'd0, dv_pxq_ff[PQ_STEPS]}));
      py_full    = 34'(fc.ay) + (fc.sy ? -34'({4'd0, dv_pyq_ff[PQ_STEPS]})
                                       : 34'({4'd0, dv_pyq_ff[PQ_STEPS]}));
      if (!fc.contact) begin
         pen_in = '0;
         nx_in  = '0;
         ny_in  = '0;
         px_in  = '0;
         py_in  = '0;
      end else if (fd == '0) begin
         pen_in = {1'b0, fc.ra};
         nx_in  = NORM_ONE;
         ny_in  = '0;
         px_in  = fc.ax;
         py_in  = fc.ay;
      end else begin
         pen_in = fc.r - fd;
         nx_in  = fc.sx ? -$signed({1'b0, dv_nxq_ff[PQ_STEPS]})
                        : $signed({1'b0, dv_nxq_ff[PQ_STEPS]});
         ny_in  = fc.sy ? -$signed({1'b0, dv_nyq_ff[PQ_STEPS]})
                        : $signed({1'b0, dv_nyq_ff[PQ_STEPS]});
         px_in  = sat32(px_full);
         py_in  = sat32(py_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= dv_v_ff[PQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ch.contact_found <= contact_in;
         rsp_ch.penetration   <= pen_in;
         rsp_ch.normal_x      <= nx_in;
         rsp_ch.normal_y      <= ny_in;
         rsp_ch.point_x       <= px_in;
         rsp_ch.point_y       <= py_in;
      end
   end
endmodule
